[sv/hmlp_pkg.sv]
// shared types and constants of the linear-probing hash table
// used by the probe engine, the hash unit and the top level
package hmlp_pkg;

	localparam int DEF_CAPACITY = 1024;
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int COUNT_W = 11;
	localparam logic [COUNT_W-1:0] MAX_ENTRIES_RST = COUNT_W'(922);
	// fibonacci hashing multiplier, taken as an unsigned 32-bit number
	localparam logic [32:0] HASH_MULT = 33'd2654435769;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_WRITE  = 2'd1,
		OP_DELETE = 2'd2,
		OP_CLEAR  = 2'd3
	} op_t;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef struct packed {
		logic                    used;
		logic                    deleted;
		logic signed [KEY_W-1:0] key;
		logic signed [VAL_W-1:0] value;
	} slot_t;

	localparam int SLOT_W = $bits(slot_t);

	typedef struct packed {
		logic signed [VAL_W-1:0] read_value;
		logic                    found;
		logic [1:0]              status;
		logic [COUNT_W-1:0]      live_count;
	} result_t;

endpackage

[sv/hash_map_linear_probe_core.sv]
// top level of the linear-probing hash table: channels, max_entries register,
// result register; uses hmlp_pkg, hmlp_ram, hmlp_hash, hmlp_probe
//
//   channel   direction  handshake              word
//   in        input      in_valid / in_stall    op, key, value
//   out       output     out_valid / out_stall  read_value, found, status, live_count
//   cfg       input      cfg_valid / cfg_ready  cfg_data (max_entries)
//
// lookup, write and delete hash the key, then probe slot by slot: each slot
// probed is one read and one evaluate on the single slot ram read port. when
// CAPACITY is not a power of two the hash unit adds quotient and remainder stages.
// clear sweeps every ram entry, one ram entry written per cycle.
// after reset a clearing pass over every slot runs with in_stall high.
// one item is worked at a time; a finished result waits in the out register
// while the next item is taken; with that register stalled the next finished
// word waits in the probe engine and in_stall stays high
module hash_map_linear_probe_core #(
	parameter int CAPACITY = hmlp_pkg::DEF_CAPACITY
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [1:0]                           op,
	input  logic signed [hmlp_pkg::KEY_W-1:0]    key,
	input  logic signed [hmlp_pkg::VAL_W-1:0]    value,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic signed [hmlp_pkg::VAL_W-1:0]    read_value,
	output logic                                 found,
	output logic [1:0]                           status,
	output logic [hmlp_pkg::COUNT_W-1:0]         live_count,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [hmlp_pkg::COUNT_W-1:0]         cfg_data
);

	import hmlp_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);

	logic               accept;
	logic               idle;
	logic               hash_done;
	logic [IDX_W-1:0]   home;
	logic               res_valid;
	logic               res_take;
	result_t            res;
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [SLOT_W-1:0]  ram_wdata;
	logic               ram_re;
	logic [IDX_W-1:0]   ram_raddr;
	logic [SLOT_W-1:0]  ram_rdata;
	logic [COUNT_W-1:0] max_entries_q;
	logic               out_valid_q;
	result_t            out_q;

	assign in_stall  = !idle;
	assign accept    = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_entries_q <= MAX_ENTRIES_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_entries_q <= cfg_data;
		end
	end

	hmlp_hash #(.CAPACITY(CAPACITY)) u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept),
		.key    (key),
		.done   (hash_done),
		.home   (home)
	);

	hmlp_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	hmlp_probe #(.CAPACITY(CAPACITY)) u_probe (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.op          (op_t'(op)),
		.key         (key),
		.value       (value),
		.max_entries (max_entries_q),
		.hash_done   (hash_done),
		.home        (home),
		.idle        (idle),
		.res_valid   (res_valid),
		.res_take    (res_take),
		.res         (res),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	// output register takes a word when empty or being drained this cycle
	assign res_take = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
			out_q       <= res;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid  = out_valid_q;
	assign read_value = out_q.read_value;
	assign found      = out_q.found;
	assign status     = out_q.status;
	assign live_count = out_q.live_count;

endmodule

[sv/hmlp_ram.sv]
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module hmlp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

[sv/hmlp_hash.sv]
// home slot unit: upper half of the signed key times the hash multiplier,
// reduced modulo CAPACITY; uses hmlp_pkg
module hmlp_hash #(
	parameter int CAPACITY = hmlp_pkg::DEF_CAPACITY,
	localparam int IDX_W = $clog2(CAPACITY)
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic signed [hmlp_pkg::KEY_W-1:0] key,
	output logic                             done,
	output logic [IDX_W-1:0]                 home
);

	import hmlp_pkg::*;

	localparam bit POW2 = (CAPACITY & (CAPACITY - 1)) == 0;

	logic signed [65:0] prod;
	logic [31:0]        hi;

	// sign-extended key times the unsigned multiplier, bits 32 to 63
	assign prod = $signed({key[KEY_W-1], key}) * $signed(HASH_MULT);
	assign hi = prod[63:32];

	if (POW2) begin : g_pow2
		logic             done_q;
		logic [IDX_W-1:0] home_s1;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				done_q <= 1'b0;
			end else begin
				done_q <= start;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				home_s1 <= hi[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign home = home_s1;
	end else begin : g_recip
		// exact quotient of a 32-bit word by multiplying with a rounded-up reciprocal
		localparam int SH = 32 + IDX_W;
		localparam logic [32:0] RECIP =
			33'(((65'd1 << SH) + 65'(CAPACITY - 1)) / 65'(CAPACITY));
		localparam logic [31:0] CAP32 = 32'(CAPACITY);

		logic             valid_s1;
		logic             valid_s2;
		logic             done_q;
		logic [31:0]      hi_s1;
		logic [31:0]      hi_s2;
		logic [31:0]      quot_s2;
		logic [IDX_W-1:0] home_s3;
		logic [64:0]      qprod;
		logic [31:0]      qcap;
		logic [31:0]      rem_full;

		assign qprod    = 65'(hi_s1) * 65'(RECIP);
		assign qcap     = quot_s2 * CAP32;
		assign rem_full = hi_s2 - qcap;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s1 <= 1'b0;
				valid_s2 <= 1'b0;
				done_q   <= 1'b0;
			end else begin
				valid_s1 <= start;
				valid_s2 <= valid_s1;
				done_q   <= valid_s2;
			end
		end

		always_ff @(posedge clk) begin
			if (start) begin
				hi_s1 <= hi;
			end
			if (valid_s1) begin
				hi_s2   <= hi_s1;
				quot_s2 <= 32'(qprod >> SH);
			end
			if (valid_s2) begin
				home_s3 <= rem_full[IDX_W-1:0];
			end
		end

		assign done = done_q;
		assign home = home_s3;
	end

endmodule

[sv/hmlp_probe.sv]
// probe sequencer: clearing sweep, slot-by-slot probe through the slot ram,
// final update and result; uses hmlp_pkg
module hmlp_probe #(
	parameter int CAPACITY = hmlp_pkg::DEF_CAPACITY,
	localparam int IDX_W = $clog2(CAPACITY)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               accept,
	input  hmlp_pkg::op_t                      op,
	input  logic signed [hmlp_pkg::KEY_W-1:0]  key,
	input  logic signed [hmlp_pkg::VAL_W-1:0]  value,
	input  logic [hmlp_pkg::COUNT_W-1:0]       max_entries,
	input  logic                               hash_done,
	input  logic [IDX_W-1:0]                   home,
	output logic                               idle,
	output logic                               res_valid,
	input  logic                               res_take,
	output hmlp_pkg::result_t                  res,
	output logic                               ram_we,
	output logic [IDX_W-1:0]                   ram_waddr,
	output logic [hmlp_pkg::SLOT_W-1:0]        ram_wdata,
	output logic                               ram_re,
	output logic [IDX_W-1:0]                   ram_raddr,
	input  logic [hmlp_pkg::SLOT_W-1:0]        ram_rdata
);

	import hmlp_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(CAPACITY - 1);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_HASH,
		S_READ,
		S_EVAL,
		S_DONE
	} state_t;

	state_t                  state_q;
	op_t                     op_q;
	logic signed [KEY_W-1:0] key_q;
	logic signed [VAL_W-1:0] value_q;
	logic [IDX_W-1:0]        idx_q;
	logic [IDX_W-1:0]        i_q;
	logic [IDX_W-1:0]        clr_idx_q;
	logic                    clr_resp_q;
	logic                    have_tomb_q;
	logic [IDX_W-1:0]        tomb_idx_q;
	logic [COUNT_W-1:0]      count_q;
	result_t                 res_q;

	slot_t              slot;
	logic               is_empty;
	logic               is_tomb;
	logic               is_hit;
	logic               stop;
	logic               tomb_any;
	logic [IDX_W-1:0]   tomb_at;
	slot_t              wslot;
	logic [COUNT_W-1:0] count_nxt;
	result_t            res_nxt;

	assign slot     = slot_t'(ram_rdata);
	assign is_empty = !slot.used;
	assign is_tomb  = slot.used && slot.deleted;
	assign is_hit   = slot.used && !slot.deleted && (slot.key == key_q);
	// a full lap without a match or an empty slot also ends the probe
	assign stop     = is_empty || is_hit || (i_q == LAST);
	assign tomb_any = have_tomb_q || is_tomb;
	assign tomb_at  = have_tomb_q ? tomb_idx_q : idx_q;

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_idx_q;
		wslot     = '0;
		count_nxt = count_q;
		res_nxt   = '{read_value: '0, found: 1'b0, status: ST_OK, live_count: count_q};
		unique case (state_q)
			S_CLEAR: begin
				ram_we = 1'b1;
			end
			S_EVAL: begin
				if (stop) begin
					unique case (op_q)
						OP_LOOKUP: begin
							if (is_hit) begin
								res_nxt.found      = 1'b1;
								res_nxt.read_value = slot.value;
							end
						end
						OP_WRITE: begin
							wslot = '{used: 1'b1, deleted: 1'b0, key: key_q, value: value_q};
							if (is_hit) begin
								ram_we        = 1'b1;
								ram_waddr     = idx_q;
								res_nxt.found = 1'b1;
							end else if (count_q >= max_entries) begin
								res_nxt.status = ST_FULL;
							end else if (tomb_any || is_empty) begin
								// reuse the first deleted slot passed, else the empty one
								ram_we    = 1'b1;
								ram_waddr = tomb_any ? tomb_at : idx_q;
								count_nxt = count_q + COUNT_W'(1);
							end else begin
								res_nxt.status = ST_FULL;
							end
						end
						OP_DELETE: begin
							wslot = '{used: 1'b1, deleted: 1'b1, key: slot.key, value: slot.value};
							if (is_hit) begin
								ram_we        = 1'b1;
								ram_waddr     = idx_q;
								res_nxt.found = 1'b1;
								if (count_q != '0) begin
									count_nxt = count_q - COUNT_W'(1);
								end
							end else begin
								res_nxt.status = ST_NOT_FOUND;
							end
						end
						OP_CLEAR: begin
						end
					endcase
					res_nxt.live_count = count_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	assign ram_wdata = wslot;
	assign ram_re    = (state_q == S_READ);
	assign ram_raddr = idx_q;
	assign idle      = (state_q == S_IDLE);
	assign res_valid = (state_q == S_DONE);
	assign res       = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			op_q        <= OP_LOOKUP;
			key_q       <= '0;
			value_q     <= '0;
			idx_q       <= '0;
			i_q         <= '0;
			clr_idx_q   <= '0;
			clr_resp_q  <= 1'b0;
			have_tomb_q <= 1'b0;
			tomb_idx_q  <= '0;
			count_q     <= '0;
			res_q       <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					if (clr_idx_q == LAST) begin
						clr_idx_q <= '0;
						if (clr_resp_q) begin
							res_q   <= res_nxt;
							state_q <= S_DONE;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						clr_idx_q <= clr_idx_q + IDX_W'(1);
					end
				end
				S_IDLE: begin
					if (accept) begin
						op_q    <= op;
						key_q   <= key;
						value_q <= value;
						if (op == OP_CLEAR) begin
							count_q    <= '0;
							clr_resp_q <= 1'b1;
							state_q    <= S_CLEAR;
						end else begin
							state_q <= S_HASH;
						end
					end
				end
				S_HASH: begin
					if (hash_done) begin
						idx_q       <= home;
						i_q         <= '0;
						have_tomb_q <= 1'b0;
						state_q     <= S_READ;
					end
				end
				S_READ: begin
					state_q <= S_EVAL;
				end
				S_EVAL: begin
					if (stop) begin
						count_q <= count_nxt;
						res_q   <= res_nxt;
						state_q <= S_DONE;
					end else begin
						if (is_tomb && !have_tomb_q) begin
							have_tomb_q <= 1'b1;
							tomb_idx_q  <= idx_q;
						end
						idx_q   <= (idx_q == LAST) ? '0 : idx_q + IDX_W'(1);
						i_q     <= i_q + IDX_W'(1);
						state_q <= S_READ;
					end
				end
				S_DONE: begin
					if (res_take) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[dv/testbench.sv]
// self-checking testbench for hash_map_linear_probe_core: directed and random table operations
// a scoreboard class predicts every result word; depends on hmlp_pkg and the core rtl
// runs at the default capacity, with random out_stall bursts and in_valid gaps

class table_scoreboard;
	logic [hmlp_pkg::KEY_W-1:0] slot_key [hmlp_pkg::DEF_CAPACITY];
	logic [hmlp_pkg::VAL_W-1:0] slot_value [hmlp_pkg::DEF_CAPACITY];
	bit slot_used [hmlp_pkg::DEF_CAPACITY];
	bit slot_deleted [hmlp_pkg::DEF_CAPACITY];
	int unsigned entry_count;
	int unsigned max_entries;
	int unsigned errors;
	hmlp_pkg::result_t pending_results[$];

	function new();
		entry_count = 0;
		max_entries = hmlp_pkg::MAX_ENTRIES_RST;
		errors = 0;
	endfunction

	// upper half of the sign-extended product, then modulo the table size
	function int unsigned home_of(logic [31:0] k);
		logic [63:0] wide;
		logic [63:0] prod;
		wide = {{32{k[31]}}, k};
		prod = wide * 64'd2654435769;
		return prod[63:32] % hmlp_pkg::DEF_CAPACITY;
	endfunction

	function void note_item(hmlp_pkg::op_t code, logic [31:0] k, logic [31:0] v);
		hmlp_pkg::result_t r;
		int unsigned first_slot, slot, hit_slot, tomb_slot, empty_slot;
		bit hit, have_tomb, have_empty;
		r = '0;
		hit = 1'b0;
		have_tomb = 1'b0;
		have_empty = 1'b0;
		hit_slot = 0;
		tomb_slot = 0;
		empty_slot = 0;
		if (code == hmlp_pkg::OP_CLEAR) begin
			foreach (slot_used[i]) begin
				slot_used[i] = 1'b0;
				slot_deleted[i] = 1'b0;
			end
			entry_count = 0;
		end else begin
			first_slot = home_of(k);
			for (int i = 0; i < hmlp_pkg::DEF_CAPACITY; i++) begin
				slot = (first_slot + i) % hmlp_pkg::DEF_CAPACITY;
				if (!slot_used[slot]) begin
					have_empty = 1'b1;
					empty_slot = slot;
					break;
				end
				if (slot_deleted[slot]) begin
					if (!have_tomb) begin
						have_tomb = 1'b1;
						tomb_slot = slot;
					end
				end else if (slot_key[slot] == k) begin
					hit = 1'b1;
					hit_slot = slot;
					break;
				end
			end
			case (code)
			hmlp_pkg::OP_LOOKUP: begin
				if (hit) begin
					r.found = 1'b1;
					r.read_value = slot_value[hit_slot];
				end
			end
			hmlp_pkg::OP_WRITE: begin
				if (hit) begin
					r.found = 1'b1;
					slot_value[hit_slot] = v;
				end else if (entry_count >= max_entries) begin
					r.status = hmlp_pkg::ST_FULL;
				end else if (have_tomb || have_empty) begin
					// first deletion mark passed wins over the empty slot
					slot = have_tomb ? tomb_slot : empty_slot;
					slot_used[slot] = 1'b1;
					slot_deleted[slot] = 1'b0;
					slot_key[slot] = k;
					slot_value[slot] = v;
					entry_count++;
				end else begin
					r.status = hmlp_pkg::ST_FULL;
				end
			end
			default: begin
				if (hit) begin
					r.found = 1'b1;
					slot_deleted[hit_slot] = 1'b1;
					if (entry_count > 0)
						entry_count--;
				end else begin
					r.status = hmlp_pkg::ST_NOT_FOUND;
				end
			end
			endcase
		end
		r.live_count = entry_count[hmlp_pkg::COUNT_W-1:0];
		pending_results.push_back(r);
	endfunction

	task report(string what, logic [31:0] got, logic [31:0] want);
		if (errors < 200)
			$display("%0t mismatch on %s: got %0h, expected %0h", $time, what, got, want);
		errors++;
	endtask

	task check_word(logic [31:0] rv, logic f, logic [1:0] st,
			logic [hmlp_pkg::COUNT_W-1:0] cnt);
		hmlp_pkg::result_t want;
		if (pending_results.size() == 0) begin
			report("word with no item pending", rv, 0);
			return;
		end
		want = pending_results.pop_front();
		if (rv !== want.read_value)
			report("read_value", rv, want.read_value);
		if (f !== want.found)
			report("found", f, want.found);
		if (st !== want.status)
			report("status", st, want.status);
		if (cnt !== want.live_count)
			report("live_count", cnt, want.live_count);
	endtask
endclass

module testbench;
	import hmlp_pkg::*;

	localparam int CAP = DEF_CAPACITY;
	localparam int QUIET_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [1:0] op;
	logic signed [KEY_W-1:0] key;
	logic signed [VAL_W-1:0] value;
	logic out_valid;
	logic out_stall;
	logic signed [VAL_W-1:0] read_value;
	logic found;
	logic [1:0] status;
	logic [COUNT_W-1:0] live_count;
	logic cfg_valid;
	logic cfg_ready;
	logic [COUNT_W-1:0] cfg_data;

	bit idle_on = 1'b1;
	int unsigned quiet_cycles = 0;
	logic [31:0] key_pool[$];
	table_scoreboard sb;

	hash_map_linear_probe_core #(
		.CAPACITY(CAP)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.op(op),
		.key(key),
		.value(value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.read_value(read_value),
		.found(found),
		.status(status),
		.live_count(live_count),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall)
				sb.check_word(read_value, found, status, live_count);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 10)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("testbench: FAIL");
		$finish;
	end

	function automatic logic [31:0] pool_key();
		return key_pool[$urandom_range(0, key_pool.size() - 1)];
	endfunction

	// walk keys upward from a start point until one hashes to the wanted slot
	function automatic logic [31:0] key_at_slot(int unsigned slot, logic [31:0] from);
		logic [31:0] k;
		k = from;
		while (sb.home_of(k) != slot)
			k++;
		return k;
	endfunction

	task automatic push_op(op_t code, logic [31:0] k, logic [31:0] v);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= code;
		key <= k;
		value <= v;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.note_item(code, k, v);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (sb.pending_results.size() != 0);
	endtask

	task automatic set_limit(int unsigned n);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_data <= COUNT_W'(n);
		do @(posedge clk); while (cfg_ready !== 1'b1);
		cfg_valid <= 1'b0;
		sb.max_entries = n;
	endtask

	task automatic mixed_ops(int unsigned count, int unsigned pool_size, int unsigned clear_pm);
		logic [31:0] k;
		int unsigned w;
		key_pool.delete();
		repeat (pool_size) key_pool.push_back($urandom);
		repeat (count) begin
			k = ($urandom_range(0, 7) == 0) ? $urandom : pool_key();
			w = $urandom_range(0, 999);
			if (w < clear_pm)
				push_op(OP_CLEAR, k, $urandom);
			else if (w < 450)
				push_op(OP_WRITE, k, $urandom);
			else if (w < 750)
				push_op(OP_LOOKUP, k, $urandom);
			else
				push_op(OP_DELETE, k, $urandom);
		end
	endtask

	initial begin
		logic [31:0] ka, kb, kc, k;
		int unsigned n;
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		op = OP_LOOKUP;
		key = '0;
		value = '0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// field extremes on an empty table
		push_op(OP_LOOKUP, 32'h0000_0000, 32'hFFFF_FFFF);
		push_op(OP_DELETE, 32'h8000_0000, 32'h0000_0000);
		push_op(OP_WRITE, 32'h8000_0000, 32'h7FFF_FFFF);
		push_op(OP_WRITE, 32'h7FFF_FFFF, 32'h8000_0000);
		push_op(OP_WRITE, 32'h0000_0000, 32'h0000_0000);
		push_op(OP_WRITE, 32'hFFFF_FFFF, 32'h5555_AAAA);
		push_op(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);
		push_op(OP_WRITE, 32'h8000_0000, 32'h0001_2345);
		push_op(OP_LOOKUP, 32'h8000_0000, 32'h0000_0000);

		// three keys sharing the last slot: wrap, skip a deletion mark, reuse it
		ka = key_at_slot(CAP - 1, 32'h0000_0001);
		kb = key_at_slot(CAP - 1, ka + 1);
		kc = key_at_slot(CAP - 1, kb + 1);
		push_op(OP_WRITE, ka, 32'h1111_1111);
		push_op(OP_WRITE, kb, 32'h2222_2222);
		push_op(OP_DELETE, ka, 32'h0000_0000);
		push_op(OP_LOOKUP, kb, 32'h0000_0000);
		push_op(OP_WRITE, kc, 32'h3333_3333);
		push_op(OP_LOOKUP, kc, 32'h0000_0000);
		push_op(OP_DELETE, kb, 32'h0000_0000);
		push_op(OP_LOOKUP, kb, 32'h0000_0000);
		push_op(OP_DELETE, kb, 32'h0000_0000);
		push_op(OP_CLEAR, kc, 32'h0000_0000);
		push_op(OP_LOOKUP, kc, 32'h0000_0000);

		// count limit of one: update of a present key still goes through
		set_limit(1);
		push_op(OP_WRITE, ka, 32'hAAAA_0001);
		push_op(OP_WRITE, kb, 32'hBBBB_0001);
		push_op(OP_WRITE, ka, 32'hAAAA_0002);
		push_op(OP_DELETE, ka, 32'h0000_0000);
		push_op(OP_WRITE, kb, 32'hBBBB_0002);

		// fill every slot, then probe a table with no free slot
		set_limit(CAP);
		key_pool.delete();
		push_op(OP_CLEAR, $urandom, $urandom);
		while (sb.entry_count < CAP) begin
			n = $urandom_range(0, 15);
			if (n == 0 && key_pool.size() > 0) begin
				push_op(OP_LOOKUP, pool_key(), $urandom);
			end else if (n == 1 && key_pool.size() > 0) begin
				push_op(OP_WRITE, pool_key(), $urandom);
			end else begin
				k = $urandom;
				key_pool.push_back(k);
				push_op(OP_WRITE, k, $urandom);
			end
		end
		repeat (3) push_op(OP_WRITE, $urandom, $urandom);
		repeat (2) push_op(OP_LOOKUP, $urandom, $urandom);
		push_op(OP_DELETE, $urandom, $urandom);
		// punch holes and refill them while no empty slot exists
		repeat (60) begin
			n = $urandom_range(0, 3);
			if (n < 2)
				push_op(OP_DELETE, pool_key(), $urandom);
			else if (n == 2)
				push_op(OP_WRITE, $urandom, $urandom);
			else
				push_op(OP_LOOKUP, pool_key(), $urandom);
		end
		push_op(OP_CLEAR, $urandom, $urandom);

		// moderate load against a mid-range count limit
		set_limit($urandom_range(60, 200));
		mixed_ops(280, 300, 0);

		// tiny limits with a small key set
		set_limit(1);
		mixed_ops(60, 8, 20);
		set_limit($urandom_range(2, 16));
		mixed_ops(100, 24, 20);

		// last part runs without any idling
		set_limit(1023);
		idle_on = 1'b0;
		mixed_ops(150, 64, 20);

		drain_results();
		repeat (40) @(posedge clk);
		if (sb.errors == 0)
			$display("testbench: PASS");
		else
			$display("testbench: FAIL");
		$finish;
	end
endmodule
